/* design/drss_pkg.sv */
// Shared types and constants for the delimited record split scanner.
`timescale 1ns / 1ps
package drss_pkg;

  localparam int POS_BITS_DEFAULT = 48;
  localparam int OFS_W = 48;
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [7:0] DELIM_RESET = 8'h0a;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DELIMITER   = 3'd0,
    REG_SPLIT_START = 3'd1,
    REG_SPLIT_END   = 3'd2,
    REG_FILE_END    = 3'd3,
    REG_SKIP_HEADER = 3'd4
  } reg_idx_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_BYTE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK             = 2'd0,
    STAT_START_PAST_END = 2'd1,
    STAT_IDLE_BYTE      = 2'd2
  } status_t;

  typedef struct packed {
    logic skip_first;
    logic skip_hdr;
    logic in_last;
    logic nonempty;
    logic active;
  } flags_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       record_end;
    logic       split_done;
    logic [1:0] status;
  } result_t;

endpackage

/* design/drss_step.sv */
// Next-state and result logic for one word of the split scan.
`timescale 1ns / 1ps
module drss_step #(
  parameter int POS_BITS = drss_pkg::POS_BITS_DEFAULT
) (
  input  logic                  action,
  input  logic [7:0]            byte_in,
  input  logic [POS_BITS-1:0]   pos,
  input  drss_pkg::flags_t      flags,
  input  logic [7:0]            delimiter,
  input  logic [POS_BITS-1:0]   s_start,
  input  logic [POS_BITS-1:0]   s_end,
  input  logic [POS_BITS-1:0]   f_end,
  input  logic                  skip_header,
  output logic [POS_BITS-1:0]   pos_next,
  output drss_pkg::flags_t      flags_next,
  output logic                  res_valid,
  output drss_pkg::result_t     res
);

  logic [POS_BITS-1:0] pos_start;
  logic [POS_BITS-1:0] pos_inc;
  logic                start_past;
  logic                is_delim;
  logic                discarding;
  logic                emit;
  logic                rec_end;
  logic                valid;
  logic                cont;
  drss_pkg::flags_t    fl;

  assign pos_start  = (s_start != '0) ? s_start - 1'b1 : '0;
  assign start_past = (s_start != '0) && (s_start >= f_end);
  assign pos_inc    = pos + 1'b1;
  assign is_delim   = (byte_in == delimiter);
  assign discarding = flags.skip_first | flags.skip_hdr;

  always_comb begin
    pos_next   = pos;
    flags_next = flags;
    res_valid  = 1'b0;
    res        = '0;
    fl         = flags;
    emit       = 1'b0;
    rec_end    = 1'b0;
    valid      = 1'b0;
    cont       = 1'b0;
    if (action == drss_pkg::ACT_START) begin
      flags_next = '0;
      if (start_past) begin
        pos_next         = s_start;
        res_valid        = 1'b1;
        res.split_done   = 1'b1;
        res.status       = drss_pkg::STAT_START_PAST_END;
      end else begin
        pos_next            = pos_start;
        flags_next.skip_first = (s_start != '0);
        flags_next.skip_hdr   = (s_start == '0) & skip_header;
        if ((pos_start >= s_end) || (pos_start >= f_end)) begin
          res_valid      = 1'b1;
          res.split_done = 1'b1;
          res.status     = drss_pkg::STAT_OK;
        end else begin
          flags_next.active = 1'b1;
        end
      end
    end else if (!flags.active) begin
      res_valid  = 1'b1;
      res.status = drss_pkg::STAT_IDLE_BYTE;
    end else begin
      pos_next = pos_inc;
      if (!is_delim) begin
        if (!discarding) begin
          valid       = 1'b1;
          emit        = 1'b1;
          fl.nonempty = 1'b1;
        end
      end else begin
        fl.in_last = 1'b0;
        if (flags.skip_first) begin
          fl.skip_first = 1'b0;
        end else if (flags.skip_hdr) begin
          fl.skip_hdr = 1'b0;
        end else begin
          emit    = 1'b1;
          rec_end = 1'b1;
        end
        fl.nonempty = 1'b0;
      end
      if (rec_end) begin
        cont = (pos_inc < s_end);
      end else begin
        if (pos_inc == s_end) begin
          fl.in_last = 1'b1;
        end
        cont = (pos_inc < s_end) || fl.in_last;
      end
      if (pos_inc >= f_end) begin
        cont = 1'b0;
      end
      res.out_byte   = valid ? byte_in : 8'h00;
      res.byte_valid = valid;
      res.status     = drss_pkg::STAT_OK;
      if (cont) begin
        flags_next     = fl;
        res_valid      = emit;
        res.record_end = rec_end;
      end else begin
        flags_next          = fl;
        flags_next.active   = 1'b0;
        flags_next.nonempty = 1'b0;
        flags_next.in_last  = 1'b0;
        res_valid           = 1'b1;
        res.record_end      = rec_end | (fl.nonempty & ~fl.skip_first & ~fl.skip_hdr);
        res.split_done      = 1'b1;
      end
    end
  end

endmodule

/* design/delimited_record_split_scanner_core.sv */
// Top level of the delimited record split scanner with register port and output skid.
// A result word is registered into the output register, or into the skid register while the output is stalled.
// Throughput: one input word per cycle while the skid register is empty; scan state is registered per accepted word.
// A skid register keeps input accepted while one result waits on the output.
// Reset (synchronous, active high) clears scan state and queues and restores
// register defaults: delimiter newline, offsets zero, header skip off.
`timescale 1ns / 1ps
module delimited_record_split_scanner_core #(
  parameter int POS_BITS = drss_pkg::POS_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drss_pkg::APB_AW-1:0] paddr,
  input  logic [drss_pkg::APB_DW-1:0] pwdata,
  output logic [drss_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [7:0]                  byte_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        record_end,
  output logic                        split_done,
  output logic [1:0]                  status
);

  logic [7:0]                  delimiter;
  logic [drss_pkg::OFS_W-1:0]  split_start;
  logic [drss_pkg::OFS_W-1:0]  split_end;
  logic [drss_pkg::OFS_W-1:0]  file_end;
  logic                        skip_header;

  logic [POS_BITS-1:0]         pos;
  logic [POS_BITS-1:0]         pos_next;
  drss_pkg::flags_t            flags;
  drss_pkg::flags_t            flags_next;
  logic                        res_valid;
  drss_pkg::result_t           res;

  drss_pkg::result_t           out_res;
  drss_pkg::result_t           skid_res;
  logic                        skid_valid;

  logic                        wr;
  drss_pkg::reg_idx_t          idx;
  logic                        accept;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = drss_pkg::reg_idx_t'(paddr[drss_pkg::APB_AW-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter   <= drss_pkg::DELIM_RESET;
      split_start <= '0;
      split_end   <= '0;
      file_end    <= '0;
      skip_header <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        drss_pkg::REG_DELIMITER:   delimiter   <= pwdata[7:0];
        drss_pkg::REG_SPLIT_START: split_start <= pwdata[drss_pkg::OFS_W-1:0];
        drss_pkg::REG_SPLIT_END:   split_end   <= pwdata[drss_pkg::OFS_W-1:0];
        drss_pkg::REG_FILE_END:    file_end    <= pwdata[drss_pkg::OFS_W-1:0];
        drss_pkg::REG_SKIP_HEADER: skip_header <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      drss_pkg::REG_DELIMITER:   prdata = drss_pkg::APB_DW'(delimiter);
      drss_pkg::REG_SPLIT_START: prdata = drss_pkg::APB_DW'(split_start);
      drss_pkg::REG_SPLIT_END:   prdata = drss_pkg::APB_DW'(split_end);
      drss_pkg::REG_FILE_END:    prdata = drss_pkg::APB_DW'(file_end);
      drss_pkg::REG_SKIP_HEADER: prdata = drss_pkg::APB_DW'(skip_header);
      default:                   prdata = '0;
    endcase
  end

  drss_step #(
    .POS_BITS(POS_BITS)
  ) u_step (
    .action      (action),
    .byte_in     (byte_in),
    .pos         (pos),
    .flags       (flags),
    .delimiter   (delimiter),
    .s_start     (POS_BITS'(split_start)),
    .s_end       (POS_BITS'(split_end)),
    .f_end       (POS_BITS'(file_end)),
    .skip_header (skip_header),
    .pos_next    (pos_next),
    .flags_next  (flags_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign in_ready = ~skid_valid;
  assign accept   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      flags      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos   <= pos_next;
        flags <= flags_next;
      end
      if (out_valid && out_ready) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else if (!(accept && res_valid)) begin
          out_valid <= 1'b0;
        end
      end
      if (accept && res_valid) begin
        if (!out_valid || out_ready) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res;
          skid_valid <= 1'b1;
        end
      end
    end
  end

  assign out_byte   = out_res.out_byte;
  assign byte_valid = out_res.byte_valid;
  assign record_end = out_res.record_end;
  assign split_done = out_res.split_done;
  assign status     = out_res.status;

endmodule

/* design/drss_checker.sv */
// Port-level checks for the split scanner, bound to the top level.
`timescale 1ns / 1ps
module drss_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       record_end,
  input logic       split_done,
  input logic [1:0] status
);

  a_past_end_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == drss_pkg::STAT_START_PAST_END |-> split_done && !byte_valid)
    else $error("start past end word without done");

  a_idle_byte_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == drss_pkg::STAT_IDLE_BYTE
      |-> !byte_valid && !record_end && !split_done && out_byte == 8'h00)
    else $error("idle byte word carries data");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == drss_pkg::STAT_OK)
    else $error("data word with error status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("output word dropped or changed while stalled");

endmodule

bind delimited_record_split_scanner_core drss_checker u_drss_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .record_end (record_end),
  .split_done (split_done),
  .status     (status)
);
